>>> hdl/hhe_pkg.sv
package hhe_pkg;

  localparam int NAME_LIMIT_MAX = 64;
  localparam int LEN_W          = 7;
  localparam int TAG_LEN        = 6;
  localparam int FIFO_DEPTH     = 4;
  localparam int PTR_W          = $clog2(FIFO_DEPTH);
  localparam int CNT_W          = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [4:0] {
    PH_SCAN    = 5'b00001,
    PH_LSTART  = 5'b00010,
    PH_MATCH   = 5'b00100,
    PH_CAPTURE = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       byte_valid;
    logic       name_end;
    logic       name_cut;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

  function automatic logic [7:0] host_tag(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_H;
      3'd1:    c = CH_O;
      3'd2:    c = CH_S;
      3'd3:    c = CH_T;
      3'd4:    c = CH_COLON;
      3'd5:    c = CH_SPACE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/hhe_parser.sv
module hhe_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      request_end_i,
  input  logic [hhe_pkg::LEN_W-1:0] max_len_i,
  input  logic                      room_i,
  output hhe_pkg::push_t            push_o
);

  typedef struct packed {
    hhe_pkg::phase_e           ph;
    logic [2:0]                mp;
    logic [hhe_pkg::LEN_W-1:0] cnt;
    logic                      cr;
    logic [1:0]                n;
    hhe_pkg::res_t             r0;
    hhe_pkg::res_t             r1;
  } work_t;

  logic                      vld_q;
  logic [7:0]                data_q;
  logic                      last_q;
  hhe_pkg::phase_e           phase_q;
  logic [2:0]                mp_q;
  logic [hhe_pkg::LEN_W-1:0] cnt_q;
  logic                      cr_q;
  logic                      move;
  logic [hhe_pkg::LEN_W-1:0] lim;
  work_t                     w;

  function automatic work_t do_finish(work_t wi, logic cut);
    work_t o;
    o = wi;
    if (o.n == 2'd2) begin
      o.r1.name_end = 1'b1;
      o.r1.name_cut = cut;
    end else if (o.n == 2'd1) begin
      o.r0.name_end = 1'b1;
      o.r0.name_cut = cut;
    end else begin
      o.r0 = '{name_byte: 8'h00, byte_valid: 1'b0, name_end: 1'b1, name_cut: cut};
      o.n  = 2'd1;
    end
    o.ph = hhe_pkg::PH_DONE;
    o.cr = 1'b0;
    return o;
  endfunction

  function automatic work_t do_emit(work_t wi, logic [7:0] b,
                                    logic [hhe_pkg::LEN_W-1:0] lm);
    work_t o;
    o = wi;
    if (o.n == 2'd0) begin
      o.r0 = '{name_byte: b, byte_valid: 1'b1, name_end: 1'b0, name_cut: 1'b0};
    end else begin
      o.r1 = '{name_byte: b, byte_valid: 1'b1, name_end: 1'b0, name_cut: 1'b0};
    end
    o.n   = o.n + 2'd1;
    o.cnt = o.cnt + 1'b1;
    if (o.cnt >= lm) begin
      o = do_finish(o, 1'b1);
    end
    return o;
  endfunction

  function automatic work_t do_scan(work_t wi, logic [7:0] b);
    work_t o;
    o = wi;
    if (o.cr) begin
      o.cr = 1'b0;
      if (b == hhe_pkg::CH_LF) begin
        o.ph = hhe_pkg::PH_LSTART;
      end
    end else if (b == hhe_pkg::CH_CR) begin
      o.cr = 1'b1;
    end
    return o;
  endfunction

  function automatic work_t do_take(work_t wi, logic [7:0] b,
                                    logic [hhe_pkg::LEN_W-1:0] lm);
    work_t o;
    o = wi;
    if (b == hhe_pkg::CH_CR) begin
      o.cr = 1'b1;
    end else begin
      o = do_emit(o, b, lm);
    end
    return o;
  endfunction

  assign move       = vld_q && room_i;
  assign in_ready_o = !vld_q || move;

  always_comb begin
    if (max_len_i == '0) begin
      lim = hhe_pkg::LEN_W'(1);
    end else if (max_len_i > hhe_pkg::LEN_W'(hhe_pkg::NAME_LIMIT_MAX)) begin
      lim = hhe_pkg::LEN_W'(hhe_pkg::NAME_LIMIT_MAX);
    end else begin
      lim = max_len_i;
    end
  end

  always_comb begin
    w    = '{ph: phase_q, mp: mp_q, cnt: cnt_q, cr: cr_q, n: 2'd0, r0: '0, r1: '0};
    case (phase_q)
      hhe_pkg::PH_SCAN: begin
        w = do_scan(w, data_q);
      end
      hhe_pkg::PH_LSTART: begin
        if (data_q == hhe_pkg::CH_H) begin
          w.ph = hhe_pkg::PH_MATCH;
          w.mp = 3'd1;
        end else begin
          w.ph = hhe_pkg::PH_SCAN;
        end
      end
      hhe_pkg::PH_MATCH: begin
        if (w.mp < 3'(hhe_pkg::TAG_LEN) && data_q == hhe_pkg::host_tag(w.mp)) begin
          w.mp = w.mp + 3'd1;
          if (w.mp >= 3'(hhe_pkg::TAG_LEN)) begin
            w.ph  = hhe_pkg::PH_CAPTURE;
            w.cnt = '0;
            w.cr  = 1'b0;
          end
        end else begin
          w.ph = hhe_pkg::PH_SCAN;
          w.mp = 3'd0;
          w    = do_scan(w, data_q);
        end
      end
      hhe_pkg::PH_CAPTURE: begin
        if (w.cr) begin
          w.cr = 1'b0;
          if (data_q == hhe_pkg::CH_LF) begin
            w = do_finish(w, 1'b0);
          end else begin
            w = do_emit(w, hhe_pkg::CH_CR, lim);
            if (w.ph == hhe_pkg::PH_CAPTURE) begin
              w = do_take(w, data_q, lim);
            end
          end
        end else begin
          w = do_take(w, data_q, lim);
        end
      end
      default: begin
      end
    endcase

    if (last_q) begin
      if (w.ph == hhe_pkg::PH_CAPTURE) begin
        if (w.cr) begin
          w.cr = 1'b0;
          w    = do_emit(w, hhe_pkg::CH_CR, lim);
        end
        if (w.ph == hhe_pkg::PH_CAPTURE) begin
          w = do_finish(w, 1'b1);
        end
      end
      w.ph  = hhe_pkg::PH_SCAN;
      w.mp  = 3'd0;
      w.cnt = '0;
      w.cr  = 1'b0;
    end
  end

  always_comb begin
    push_o.count = move ? w.n : 2'd0;
    push_o.res0  = w.r0;
    push_o.res1  = w.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_byte_i;
      last_q <= request_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hhe_pkg::PH_SCAN;
      mp_q    <= 3'd0;
      cnt_q   <= '0;
      cr_q    <= 1'b0;
    end else if (move) begin
      phase_q <= w.ph;
      mp_q    <= w.mp;
      cnt_q   <= w.cnt;
      cr_q    <= w.cr;
    end
  end

endmodule

>>> hdl/hhe_result_fifo.sv
module hhe_result_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hhe_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hhe_pkg::res_t  res_o
);

  hhe_pkg::res_t                mem_q [hhe_pkg::FIFO_DEPTH];
  logic [hhe_pkg::PTR_W-1:0]    wr_ptr_q;
  logic [hhe_pkg::PTR_W-1:0]    rd_ptr_q;
  logic [hhe_pkg::CNT_W-1:0]    cnt_q;
  logic                         pop;

  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign res_o       = mem_q[rd_ptr_q];
  assign room_o      = cnt_q <= hhe_pkg::CNT_W'(hhe_pkg::FIFO_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + 1'b1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + hhe_pkg::PTR_W'(push_i.count);
      rd_ptr_q <= rd_ptr_q + hhe_pkg::PTR_W'(pop);
      cnt_q    <= cnt_q + hhe_pkg::CNT_W'(push_i.count) - hhe_pkg::CNT_W'(pop);
    end
  end

endmodule

>>> hdl/http_host_header_extractor.sv
// Extracts the Host header value from an HTTP request streamed one byte per
// handshake, with request_end_i on the last byte. Every line after the first is
// tested for a leading "Host: "; the bytes that follow come out as name bytes
// until CR LF, the max_name_len limit (clamped to 1..64, reset 64) or the end
// of the request closes the name, the last two with name_cut_o. Only the
// first name of a request is reported. Throughput is one byte per cycle, with
// each byte passing through the input register and the result queue;
// a byte can yield two results (a held CR plus the next byte), and input
// stalls only while the four-entry result queue lacks room for two results.
// Write max_name_len only while the block is idle.
module http_host_header_extractor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      request_end_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                name_byte_o,
  output logic                      byte_valid_o,
  output logic                      name_end_o,
  output logic                      name_cut_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [hhe_pkg::LEN_W-1:0] cfg_data_i
);

  logic [hhe_pkg::LEN_W-1:0] max_len_q;
  logic                      room;
  hhe_pkg::push_t            push;
  hhe_pkg::res_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= hhe_pkg::LEN_W'(hhe_pkg::NAME_LIMIT_MAX);
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  hhe_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .request_end_i (request_end_i),
    .max_len_i     (max_len_q),
    .room_i        (room),
    .push_o        (push)
  );

  hhe_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign name_byte_o  = res.name_byte;
  assign byte_valid_o = res.byte_valid;
  assign name_end_o   = res.name_end;
  assign name_cut_o   = res.name_cut;

endmodule

>>> hdl/hhe_checker.sv
module hhe_port_checks (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] name_byte_o,
  input logic       byte_valid_o,
  input logic       name_end_o,
  input logic       name_cut_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(name_byte_o) &&
      $stable(byte_valid_o) && $stable(name_end_o) && $stable(name_cut_o))
    else $error("result changed while stalled");

  a_empty_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> name_byte_o == 8'h00)
    else $error("name byte set without byte_valid");

  a_cut_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && name_cut_o |-> name_end_o)
    else $error("name_cut without name_end");

  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> name_end_o)
    else $error("result without byte does not close the name");

endmodule

bind http_host_header_extractor hhe_port_checks u_port_checks (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .name_byte_o  (name_byte_o),
  .byte_valid_o (byte_valid_o),
  .name_end_o   (name_end_o),
  .name_cut_o   (name_cut_o)
);
